FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define TLVA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlva assertion failed");

// Property checked at every edge, reset included.
`define TLVA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlva assertion failed");

`endif

FILE: hdl/tlva_pkg.sv
// Package: shared constants, types and state encodings.
`default_nettype none
package tlva_pkg;

  localparam int NODES_DEFAULT = 1024;
  localparam int IDX_W         = 10;
  localparam int COORD_W       = 24;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int DMAG_W        = PROD_W + 1;
  localparam int RATE_W        = 32;
  localparam int AREA_W        = 32;
  localparam int AREA6_W       = AREA_W + 3;
  localparam int DIV_W         = AREA6_W + 16;
  localparam int NUM_W         = 83;
  localparam int SUM_W         = 48;
  localparam int TERM_W        = SUM_W + 1;
  localparam int QDEPTH        = 2;

  typedef enum logic {
    MODE_ACC  = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                      mode;
    logic [IDX_W-1:0]           node_a;
    logic [IDX_W-1:0]           node_b;
    logic [IDX_W-1:0]           node_c;
    logic signed [TERM_W-1:0]   term;
  } job_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DIFF, F_MUL, F_ABS, F_PLO, F_PHI, F_SUM, F_DIV, F_FIN, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR, B_IDLE, B_RD, B_WR
  } back_state_t;

endpackage
`default_nettype wire

FILE: hdl/tlva_if.sv
// Channel interfaces: element/read items in, node sums out.
`default_nettype none
interface item_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [9:0]                         node_a;
  logic [9:0]                         node_b;
  logic [9:0]                         node_c;
  logic signed [23:0]                 ax;
  logic signed [23:0]                 ay;
  logic signed [23:0]                 bx;
  logic signed [23:0]                 by;
  logic signed [23:0]                 cx;
  logic signed [23:0]                 cy;
  logic signed [31:0]                 cell_rate;
  logic [31:0]                        cell_area;

  modport source (output valid, mode, node_a, node_b, node_c, ax, ay, bx, by, cx, cy,
                  cell_rate, cell_area, input ready);
  modport sink (input valid, mode, node_a, node_b, node_c, ax, ay, bx, by, cx, cy,
                cell_rate, cell_area, output ready);
endinterface

interface result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] node_sum;
  logic [9:0]         node_index;

  modport source (output valid, node_sum, node_index, input ready);
  modport sink (input valid, node_sum, node_index, output ready);
endinterface
`default_nettype wire

FILE: hdl/triangle_load_vector_assembly.sv
// Top level: linear-triangle load vector assembly into a node-sum memory.
//
//   channel   dir  beat contents
//   in_item   in   mode, node_a..node_c, ax..cy, cell_rate, cell_area
//   out_res   out  node_sum, node_index (one beat per read item)
//
// With the queue free, an element passes the front end, from one accepted
// beat to the next, through difference, multiply, magnitude, two partial
// products and sum steps, a radix-2 divider, a sign step, a push step and
// an idle step. Zero area skips the divider. A read item goes from the
// idle state straight to the push state. The back end takes a job in its
// idle state, then reads and then writes memory for each node it covers.
// After reset a sweep zeroes the memory; no beat is taken until it ends.
// A two-entry queue lets the divider run while the back end waits on a
// stalled result register.
`default_nettype none
module triangle_load_vector_assembly #(
  parameter int NODES = tlva_pkg::NODES_DEFAULT
) (
  input  wire   clk,
  input  wire   rst,
  item_if.sink  in_item,
  result_if.source out_res
);
  import tlva_pkg::*;

  job_t front_job, back_job;
  logic front_valid, front_ready, back_valid, back_ready;
  logic clear_done;

  // Front end: classify and compute the term; hold off until memory is cleared.
  tlva_front u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (clear_done),
    .in_item   (in_item),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // Decouple the divider from the memory updates.
  tlva_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_job   (front_job),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_job   (back_job),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  // Back end: saturating read-modify-write on node sums, read and clear.
  tlva_back #(
    .NODES (NODES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (back_job),
    .job_valid  (back_valid),
    .job_ready  (back_ready),
    .clear_done (clear_done),
    .out_res    (out_res)
  );

endmodule
`default_nettype wire

FILE: hdl/tlva_front.sv
// Front end: accept items, compute the element term with a serial divider.
`default_nettype none
module tlva_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 enable,
  item_if.sink                in_item,
  output tlva_pkg::job_t      job,
  output logic                job_valid,
  input  wire                 job_ready
);
  import tlva_pkg::*;

  front_state_t state, state_next;

  mode_t                     mode;
  logic [IDX_W-1:0]          na, nb, nc;
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [RATE_W-1:0]  rate;
  logic [AREA_W-1:0]         area;
  logic signed [DIFF_W-1:0]  e1x, e1y, e2x, e2y;
  logic signed [PROD_W-1:0]  p1, p2;
  logic signed [DMAG_W-1:0]  det;
  logic [DMAG_W-1:0]         dmag;
  logic [RATE_W-1:0]         rmag;
  logic [AREA6_W-1:0]        area6;
  logic [63:0]               plo;
  logic [DMAG_W-32+RATE_W-1:0] phi;
  logic [NUM_W-1:0]          num;
  logic [DIV_W-1:0]          rem;
  logic [DIV_W:0]            rem_sh;
  logic                      ge;
  logic [SUM_W-1:0]          q;
  logic                      over;
  logic [6:0]                cnt;
  logic [SUM_W-1:0]          mag;
  logic signed [TERM_W-1:0]  term;
  logic [DIV_W-1:0]          dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_item.ready  = 1'b0;
    job_valid      = 1'b0;
    case (state)
      F_IDLE: begin
        in_item.ready = enable;
        if (enable && in_item.valid) begin
          state_next = (in_item.mode == MODE_READ) ? F_PUSH : F_DIFF;
        end
      end
      F_DIFF: state_next = F_MUL;
      F_MUL:  state_next = F_ABS;
      F_ABS:  state_next = F_PLO;
      F_PLO:  state_next = F_PHI;
      F_PHI:  state_next = F_SUM;
      F_SUM:  state_next = (area == '0) ? F_FIN : F_DIV;
      F_DIV:  state_next = (cnt == 7'(NUM_W - 1)) ? F_FIN : F_DIV;
      F_FIN:  state_next = F_PUSH;
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign det    = DMAG_W'(p1) - DMAG_W'(p2);
  assign dvs    = {area6, 16'b0};
  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign mag    = (over || q > {1'b1, {(SUM_W-1){1'b0}}}) ? {1'b1, {(SUM_W-1){1'b0}}} : q;

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        mode <= mode_t'(in_item.mode);
        na   <= in_item.node_a;
        nb   <= in_item.node_b;
        nc   <= in_item.node_c;
        ax   <= in_item.ax;
        ay   <= in_item.ay;
        bx   <= in_item.bx;
        by   <= in_item.by;
        cx   <= in_item.cx;
        cy   <= in_item.cy;
        rate <= in_item.cell_rate;
        area <= in_item.cell_area;
      end
      F_DIFF: begin
        e1x   <= DIFF_W'(cx) - DIFF_W'(ax);
        e1y   <= DIFF_W'(by) - DIFF_W'(ay);
        e2y   <= DIFF_W'(cy) - DIFF_W'(ay);
        e2x   <= DIFF_W'(bx) - DIFF_W'(ax);
        area6 <= ({3'b0, area} << 2) + ({3'b0, area} << 1);
      end
      F_MUL: begin
        p1 <= e1x * e1y;
        p2 <= e2y * e2x;
      end
      F_ABS: begin
        dmag <= det[DMAG_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
        rmag <= rate[RATE_W-1] ? RATE_W'(-rate) : RATE_W'(rate);
      end
      F_PLO: plo <= 64'(dmag[31:0]) * 64'(rmag);
      F_PHI: phi <= ($bits(phi))'(dmag[DMAG_W-1:32]) * ($bits(phi))'(rmag);
      F_SUM: begin
        // round to nearest: add half the divisor before dividing
        num  <= {phi, 32'b0} + NUM_W'(plo) + NUM_W'(dvs >> 1);
        rem  <= '0;
        q    <= '0;
        over <= 1'b0;
        cnt  <= '0;
      end
      F_DIV: begin
        // one quotient bit per cycle, sticky flag on overflow past the clamp
        num  <= num << 1;
        rem  <= ge ? DIV_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_W-1:0];
        q    <= {q[SUM_W-2:0], ge};
        over <= over | q[SUM_W-1];
        cnt  <= cnt + 7'd1;
      end
      F_FIN: term <= rate[RATE_W-1] ? -TERM_W'(mag) : TERM_W'(mag);
      default: ;
    endcase
  end

  assign job.mode   = mode;
  assign job.node_a = na;
  assign job.node_b = nb;
  assign job.node_c = nc;
  assign job.term   = term;

endmodule
`default_nettype wire

FILE: hdl/tlva_queue.sv
// Short job queue between the front and back ends.
`default_nettype none
module tlva_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  tlva_pkg::job_t      wr_job,
  input  wire                 wr_valid,
  output logic                wr_ready,
  output tlva_pkg::job_t      rd_job,
  output logic                rd_valid,
  input  wire                 rd_ready
);
  import tlva_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t            slots [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;
  logic            push, pop;

  assign wr_ready = count != (PW+1)'(QDEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/tlva_back.sv
// Back end: node-sum memory, clearing sweep, read-modify-write and result register.
`default_nettype none
module tlva_back #(
  parameter int NODES = tlva_pkg::NODES_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  tlva_pkg::job_t      job,
  input  wire                 job_valid,
  output logic                job_ready,
  output logic                clear_done,
  result_if.source            out_res
);
  import tlva_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);
  localparam logic signed [SUM_W+1:0] SMAX = (SUM_W+2)'({1'b0, {(SUM_W-1){1'b1}}});

  back_state_t state, state_next;

  logic signed [SUM_W-1:0]  mem [NODES];
  logic signed [SUM_W-1:0]  rdata;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [SUM_W-1:0]  wdata;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            clr;
  job_t                     cur;
  logic [1:0]               vsel;
  logic [IDX_W-1:0]         cur_idx;
  logic [16:0]              idx_wide;
  logic                     idx_ok;
  logic signed [SUM_W+1:0]  sum_raw;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     out_free;
  logic                     load_out;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  node_sum;
  logic [IDX_W-1:0]         node_index;

  assign cur_idx  = (vsel == 2'd0) ? cur.node_a : (vsel == 2'd1) ? cur.node_b : cur.node_c;
  assign idx_wide = {7'b0, cur_idx};
  assign idx_ok   = idx_wide < 17'(NODES);
  assign addr     = idx_wide[AW-1:0];
  assign sum_raw  = (SUM_W+2)'(rdata) + (SUM_W+2)'(cur.term);
  assign sum_sat  = (sum_raw > SMAX) ? {1'b0, {(SUM_W-1){1'b1}}} :
                    (sum_raw < -SMAX - 1) ? {1'b1, {(SUM_W-1){1'b0}}} :
                    sum_raw[SUM_W-1:0];
  assign out_free = !out_valid || out_res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    we         = 1'b0;
    waddr      = addr;
    wdata      = sum_sat;
    load_out   = 1'b0;
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
        if (clr == LAST) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = B_RD;
        end
      end
      B_RD: state_next = B_WR;
      B_WR: begin
        if (cur.mode == MODE_READ) begin
          if (out_free) begin
            we         = idx_ok;
            wdata      = '0;
            load_out   = 1'b1;
            state_next = B_IDLE;
          end
        end else begin
          we         = idx_ok;
          state_next = (vsel == 2'd2) ? B_IDLE : B_RD;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      clear_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clr <= clr + 1'b1;
        if (clr == LAST) begin
          clear_done <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && job_valid) begin
      cur  <= job;
      vsel <= 2'd0;
    end else if (state == B_WR && cur.mode == MODE_ACC) begin
      vsel <= vsel + 2'd1;
    end
    if (load_out) begin
      node_sum   <= idx_ok ? rdata : '0;
      node_index <= cur.node_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  assign out_res.valid      = out_valid;
  assign out_res.node_sum   = node_sum;
  assign out_res.node_index = node_index;

endmodule
`default_nettype wire

FILE: hdl/tlva_checker.sv
// Port-level checker for the top level, attached by bind.
`default_nettype none
`include "assert_macros.svh"
module tlva_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [9:0] node_index
);

  // a result held back by the sink stays offered
  `TLVA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `TLVA_ASSERT(a_idx_hold, clk, rst, out_valid && !out_ready |=> $stable(node_index))
  // memory sweep follows reset: no beat taken and no result offered right after it
  `TLVA_ASSERT_ALWAYS(a_rst_block, clk, rst |=> !in_ready && !out_valid)
  // one item at a time in the front end
  `TLVA_ASSERT(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready)

endmodule

bind triangle_load_vector_assembly tlva_checker u_tlva_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .node_index (out_res.node_index)
);
`default_nettype wire

FILE: test/triangle_load_vector_assembly_test.sv
// Testbench for the triangle load vector assembly block: directed and random element/read beats.
`timescale 1ns / 1ps
module triangle_load_vector_assembly_test;
  import tlva_pkg::*;

  localparam int    NODE_COUNT  = NODES_DEFAULT;
  localparam int    DRAIN       = 400;      // covers an element in the front end
  localparam int    LIMIT       = 1000000;
  localparam int    RANDOM_BEATS = 1500;
  localparam longint SUM_HI     = 64'sd140737488355327;
  localparam longint SUM_LO     = -SUM_HI - 1;

  typedef struct {
    mode_t              mode;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic [9:0]         node_c;
    logic signed [23:0] ax, ay, bx, by, cx, cy;
    logic signed [31:0] cell_rate;
    logic [31:0]        cell_area;
  } element_t;

  typedef struct {
    longint     sum;
    logic [9:0] idx;
  } node_read_t;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   mismatches = 0;
  bit   no_idle = 1'b0;

  // Shadow of the node-sum memory and reads still to come back.
  longint     shadow_sums [NODE_COUNT];
  node_read_t pending_reads [$];

  item_if   in_ch ();
  result_if res_ch ();

  triangle_load_vector_assembly DUT (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch),
    .out_res (res_ch)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Element term: |det| * |rate| / (6 * area * 2^16), rounded half away from zero
  // on the magnitude, clamped to 2^47, sign of the rate applied.
  function automatic longint element_term(element_t e);
    longint       dx_c, dy_b, dy_c, dx_b, det, dmag, rmag, t;
    logic [127:0] num, div, quo;
    dx_c = longint'(e.cx) - longint'(e.ax);
    dy_b = longint'(e.by) - longint'(e.ay);
    dy_c = longint'(e.cy) - longint'(e.ay);
    dx_b = longint'(e.bx) - longint'(e.ax);
    det  = dx_c * dy_b - dy_c * dx_b;
    dmag = det < 0 ? -det : det;
    rmag = e.cell_rate < 0 ? -longint'(e.cell_rate) : longint'(e.cell_rate);
    if (e.cell_area == 0) return 0;
    div = 128'(e.cell_area) * 128'd6 * 128'd65536;
    num = 128'(dmag) * 128'(rmag) + (div >> 1);
    quo = num / div;
    if (quo > (128'd1 << 47)) quo = 128'd1 << 47;
    t = longint'(quo[63:0]);
    return e.cell_rate < 0 ? -t : t;
  endfunction

  function automatic void add_to_node(logic [9:0] idx, longint t);
    longint s;
    if (idx >= NODE_COUNT) return;
    s = shadow_sums[idx] + t;
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    shadow_sums[idx] = s;
  endfunction

  // Update the shadow memory for one accepted beat.
  function automatic void apply_beat(element_t e);
    longint     t;
    node_read_t r;
    if (e.mode == MODE_READ) begin
      r.idx = e.node_a;
      r.sum = 0;
      if (e.node_a < NODE_COUNT) begin
        r.sum = shadow_sums[e.node_a];
        shadow_sums[e.node_a] = 0;
      end
      pending_reads.push_back(r);
    end else begin
      t = element_term(e);
      add_to_node(e.node_a, t);
      add_to_node(e.node_b, t);
      add_to_node(e.node_c, t);
    end
  endfunction

  // Drive one beat; valid stays high across back-to-back beats.
  task automatic send_beat(element_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= e.mode;
    in_ch.node_a    <= e.node_a;
    in_ch.node_b    <= e.node_b;
    in_ch.node_c    <= e.node_c;
    in_ch.ax        <= e.ax;
    in_ch.ay        <= e.ay;
    in_ch.bx        <= e.bx;
    in_ch.by        <= e.by;
    in_ch.cx        <= e.cx;
    in_ch.cy        <= e.cy;
    in_ch.cell_rate <= e.cell_rate;
    in_ch.cell_area <= e.cell_area;
    do @(posedge clk); while (!in_ch.ready);
    apply_beat(e);
  endtask

  task automatic send_read(logic [9:0] idx);
    element_t e;
    e = '{mode: MODE_READ, default: '0};
    e.node_a    = idx;
    e.node_b    = 10'($urandom);
    e.node_c    = 10'($urandom);
    e.cell_rate = $urandom;
    e.cell_area = $urandom;
    send_beat(e);
  endtask

  task automatic send_element(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                              logic signed [23:0] ax, logic signed [23:0] ay,
                              logic signed [23:0] bx, logic signed [23:0] by,
                              logic signed [23:0] cx, logic signed [23:0] cy,
                              logic signed [31:0] rate, logic [31:0] area);
    element_t e;
    e = '{mode: MODE_ACC, node_a: a, node_b: b, node_c: c, ax: ax, ay: ay,
          bx: bx, by: by, cx: cx, cy: cy, cell_rate: rate, cell_area: area};
    send_beat(e);
  endtask

  // Result sink: random stalls, compare each beat with the oldest read.
  initial begin : result_checker
    int         stall;
    node_read_t exp_r;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(5);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: node_index %0d node_sum %0d",
                   res_ch.node_index, res_ch.node_sum);
      end else begin
        exp_r = pending_reads.pop_front();
        if (res_ch.node_sum !== exp_r.sum[47:0] || res_ch.node_index !== exp_r.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected node %0d sum %0d, got node %0d sum %0d",
                     exp_r.idx, $signed(exp_r.sum[47:0]),
                     res_ch.node_index, res_ch.node_sum);
        end
      end
    end
  end

  // Untouched nodes read back zero, including the top index.
  task automatic test_reads_after_reset();
    send_read(10'd0);
    send_read(10'd1023);
    send_read(10'd17);
  endtask

  // Coordinate, rate and area extremes; saturation both ways.
  task automatic test_extremes();
    // Clamped term on every vertex, added twice: node 5 saturates high.
    send_element(10'd5, 10'd6, 10'd7, -24'sd8388608, -24'sd8388608,
                 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
                 32'sh7FFFFFFF, 32'd1);
    send_element(10'd5, 10'd1023, 10'd0, -24'sd8388608, -24'sd8388608,
                 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
                 32'sh7FFFFFFF, 32'd1);
    send_read(10'd5);
    // Most negative rate, node 8 on two vertices: node 8 saturates low.
    send_element(10'd8, 10'd8, 10'd9, 24'sd8388607, 24'sd8388607,
                 -24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608,
                 32'sh80000000, 32'd1);
    send_read(10'd8);
    send_read(10'd9);
    // Largest area: the term rounds to zero.
    send_element(10'd10, 10'd11, 10'd12, 24'sd0, 24'sd0, 24'sd65536, 24'sd0,
                 24'sd0, 24'sd65536, 32'sd65536, 32'hFFFFFFFF);
    send_read(10'd10);
    send_read(10'd6);
    send_read(10'd0);
  endtask

  // Zero area, degenerate triangle, repeated nodes with a negative rate, read clears.
  task automatic test_special_cases();
    // Zero area adds nothing.
    send_element(10'd20, 10'd21, 10'd22, 24'sd0, 24'sd0, 24'sd65536, 24'sd0,
                 24'sd0, 24'sd65536, 32'sd65536, 32'd0);
    send_read(10'd20);
    // Collinear vertices: det is zero.
    send_element(10'd23, 10'd24, 10'd25, 24'sd0, 24'sd0, 24'sd65536, 24'sd65536,
                 24'sd131072, 24'sd131072, 32'sd65536, 32'd65536);
    send_read(10'd23);
    // One node on all three vertices takes the term three times.
    send_element(10'd30, 10'd30, 10'd30, 24'sd0, 24'sd0, 24'sd196608, 24'sd0,
                 24'sd0, 24'sd131072, -32'sd98304, 32'd65536);
    send_read(10'd30);
    // Read clears: second read returns zero.
    send_read(10'd30);
  endtask

  function automatic logic signed [23:0] rand_coord(bit wide);
    return wide ? 24'($urandom) : 24'($signed($urandom_range(2097152)) - 1048576);
  endfunction

  // Mostly elements on a small node pool so reads see real sums.
  task automatic test_random_stream();
    element_t e;
    bit       wide;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 300 == 0) no_idle = ($urandom_range(3) == 0);
      wide = ($urandom_range(7) == 0);
      e.mode   = ($urandom_range(3) == 0) ? MODE_READ : MODE_ACC;
      e.node_a = wide ? 10'($urandom) : 10'($urandom_range(31));
      e.node_b = wide ? 10'($urandom) : 10'($urandom_range(31));
      e.node_c = wide ? 10'($urandom) : 10'($urandom_range(31));
      e.ax = rand_coord(wide);
      e.ay = rand_coord(wide);
      e.bx = rand_coord(wide);
      e.by = rand_coord(wide);
      e.cx = rand_coord(wide);
      e.cy = rand_coord(wide);
      e.cell_rate = wide ? 32'($urandom) : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      case ($urandom_range(9))
        0:       e.cell_area = 32'd0;
        1:       e.cell_area = $urandom;
        2:       e.cell_area = 32'($urandom_range(16) + 1);
        default: e.cell_area = 32'($urandom_range(1 << 20) + 1024);
      endcase
      send_beat(e);
    end
    no_idle = 1'b0;
    // Sweep the small pool so its accumulated sums get read back.
    for (int k = 0; k < 32; k++) send_read(10'(k));
  endtask

  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_ACC;
    in_ch.node_a    <= '0;
    in_ch.node_b    <= '0;
    in_ch.node_c    <= '0;
    in_ch.ax        <= '0;
    in_ch.ay        <= '0;
    in_ch.bx        <= '0;
    in_ch.by        <= '0;
    in_ch.cx        <= '0;
    in_ch.cy        <= '0;
    in_ch.cell_rate <= '0;
    in_ch.cell_area <= '0;
    res_ch.ready    <= 1'b0;
    foreach (shadow_sums[i]) shadow_sums[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reads_after_reset();
    test_extremes();
    test_special_cases();
    test_random_stream();

    @(posedge clk);
    in_ch.valid <= 1'b0;
    // Drain outstanding reads, then give the pipeline time to settle.
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tlva_pkg.sv
hdl/tlva_if.sv
hdl/tlva_front.sv
hdl/tlva_queue.sv
hdl/tlva_back.sv
hdl/triangle_load_vector_assembly.sv
hdl/tlva_checker.sv
test/triangle_load_vector_assembly_test.sv
